@@ rtl/sktb_pkg.sv @@
// Package for the sorted key table: widths, types, request and status codes.
// No dependencies; every other file in this block uses it.
package sktb_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int GRP = 8;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

  typedef logic signed [31:0] key_t;
  typedef logic [63:0] payload_t;
  typedef logic [1:0] req_type_t;
  typedef logic [CNT_W-1:0] count_t;

  localparam req_type_t OP_INS = 2'd0;
  localparam req_type_t OP_DEL = 2'd1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

@@ rtl/sktb_req_if.sv @@
// Request channel of the sorted key table: valid/ready plus operation fields.
// Depends on sktb_pkg.
interface sktb_req_if;
  logic                valid;
  logic                ready;
  sktb_pkg::req_type_t req_type;
  sktb_pkg::key_t      key;
  sktb_pkg::payload_t  payload;

  modport source (output valid, req_type, key, payload, input ready);
  modport sink (input valid, req_type, key, payload, output ready);
endinterface

@@ rtl/sktb_rsp_if.sv @@
// Result channel of the sorted key table: valid/ready plus status fields.
// Depends on sktb_pkg.
interface sktb_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  sktb_pkg::payload_t found_payload;
  logic [6:0]         entry_count;

  modport source (output valid, status, found_payload, entry_count, input ready);
  modport sink (input valid, status, found_payload, entry_count, output ready);
endinterface

@@ rtl/sorted_key_table_unit.sv @@
// Top level of the sorted key table: request sequencer, row of cells and
// match reduction. Depends on sktb_pkg, sktb_req_if, sktb_rsp_if, sktb_cell, sktb_grp.
//
//   port  direction  fields
//   req   in         req_type, key, payload
//   rsp   out        status, found_payload, entry_count
//
// A request passes through accept, compare in every cell, group reduction
// of the matches, then the result and the shift of the row.
// The finishing cycle waits while an earlier result is still held in rsp.
// Reset clears the entry count and the sequencer; entries are not cleared.
module sorted_key_table_unit (
  input logic clk,
  input logic rst,
  sktb_req_if.sink   req,
  sktb_rsp_if.source rsp
);
  import sktb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_GRP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t    state, state_next;
  count_t    count, count_next;
  req_type_t op;
  key_t      req_key;
  payload_t  req_payload;
  cell_ctl_t ctl;
  logic      fin_go;
  logic      any;
  payload_t  orpay;
  status_t   status_next;
  payload_t  found_next;
  logic      full;

  key_t     cell_key [CAPACITY];
  payload_t cell_pay [CAPACITY];
  logic [CAPACITY-1:0] cell_gt, cell_eq, occ, at_end;

  logic [NGRP*GRP-1:0] eq_pad;
  payload_t pay_pad [NGRP*GRP];
  logic [NGRP-1:0] grp_any;
  payload_t grp_pay [NGRP];

  assign req.ready = (state == S_IDLE);
  assign fin_go = (state == S_FIN) && (!rsp.valid || rsp.ready);
  assign full = (count == count_t'(CAPACITY));

  always_comb begin
    any   = |grp_any;
    orpay = '0;
    for (int g = 0; g < NGRP; g++) begin
      orpay = orpay | grp_pay[g];
    end
  end

  always_comb begin
    status_next = ST_OK;
    found_next  = '0;
    count_next  = count;
    if (op == OP_INS) begin
      if (full) begin
        status_next = ST_FULL;
      end else if (any) begin
        status_next = ST_DUP;
      end else begin
        count_next = count + count_t'(1);
      end
    end else if (count == '0) begin
      status_next = ST_EMPTY;
    end else if (!any) begin
      status_next = ST_MISSING;
    end else begin
      found_next = orpay;
      if (op == OP_DEL) begin
        count_next = count - count_t'(1);
      end
    end
  end

  always_comb begin
    ctl.cmp = (state == S_CMP);
    ctl.ins = fin_go && (op == OP_INS) && !full && !any;
    ctl.del = fin_go && (op == OP_DEL) && any;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_CMP;
      end
      S_CMP: state_next = S_GRP;
      S_GRP: state_next = S_FIN;
      S_FIN: begin
        if (fin_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_go) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op          <= req.req_type;
      req_key     <= req.key;
      req_payload <= req.payload;
    end
    if (fin_go) begin
      rsp.status        <= status_next;
      rsp.found_payload <= found_next;
      rsp.entry_count   <= 7'(count_next);
    end
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    assign occ[gi]    = count_t'(gi) < count;
    assign at_end[gi] = count_t'(gi) == count;

    if (gi == 0) begin : g_first
      sktb_cell u_cell (
        .clk, .ctl, .req_key, .req_payload,
        .occ(occ[gi]), .at_end(at_end[gi]),
        .prev_gt(1'b0), .prev_key(req_key), .prev_payload(req_payload),
        .next_key(cell_key[gi+1]), .next_payload(cell_pay[gi+1]),
        .key(cell_key[gi]), .payload(cell_pay[gi]),
        .gt(cell_gt[gi]), .eq(cell_eq[gi])
      );
    end else if (gi == CAPACITY - 1) begin : g_last
      sktb_cell u_cell (
        .clk, .ctl, .req_key, .req_payload,
        .occ(occ[gi]), .at_end(at_end[gi]),
        .prev_gt(cell_gt[gi-1]), .prev_key(cell_key[gi-1]),
        .prev_payload(cell_pay[gi-1]),
        .next_key(cell_key[gi]), .next_payload(cell_pay[gi]),
        .key(cell_key[gi]), .payload(cell_pay[gi]),
        .gt(cell_gt[gi]), .eq(cell_eq[gi])
      );
    end else begin : g_mid
      sktb_cell u_cell (
        .clk, .ctl, .req_key, .req_payload,
        .occ(occ[gi]), .at_end(at_end[gi]),
        .prev_gt(cell_gt[gi-1]), .prev_key(cell_key[gi-1]),
        .prev_payload(cell_pay[gi-1]),
        .next_key(cell_key[gi+1]), .next_payload(cell_pay[gi+1]),
        .key(cell_key[gi]), .payload(cell_pay[gi]),
        .gt(cell_gt[gi]), .eq(cell_eq[gi])
      );
    end
  end

  for (genvar pi = 0; pi < NGRP * GRP; pi++) begin : g_pad
    if (pi < CAPACITY) begin : g_used
      assign eq_pad[pi]  = cell_eq[pi];
      assign pay_pad[pi] = cell_pay[pi];
    end else begin : g_fill
      assign eq_pad[pi]  = 1'b0;
      assign pay_pad[pi] = '0;
    end
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    sktb_grp u_grp (
      .clk,
      .eq(eq_pad[g*GRP +: GRP]),
      .pay(pay_pad[g*GRP : g*GRP + GRP - 1]),
      .any(grp_any[g]),
      .orpay(grp_pay[g])
    );
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_CMP)
    else $error("accepted request did not start its compare");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + count_t'(1))
    else $error("insert did not grow the entry count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.found_payload == '0)
    else $error("failed request carries a payload");

endmodule

@@ rtl/sktb_cell.sv @@
// One entry of the sorted table: key, payload and its compare flags.
// Shifts toward either neighbor on insert or delete. Depends on sktb_pkg.
module sktb_cell (
  input  logic                clk,
  input  sktb_pkg::cell_ctl_t ctl,
  input  sktb_pkg::key_t      req_key,
  input  sktb_pkg::payload_t  req_payload,
  input  logic                occ,
  input  logic                at_end,
  input  logic                prev_gt,
  input  sktb_pkg::key_t      prev_key,
  input  sktb_pkg::payload_t  prev_payload,
  input  sktb_pkg::key_t      next_key,
  input  sktb_pkg::payload_t  next_payload,
  output sktb_pkg::key_t      key,
  output sktb_pkg::payload_t  payload,
  output logic                gt,
  output logic                eq
);
  import sktb_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      gt <= occ && (key > req_key);
      eq <= occ && (key == req_key);
    end
    if (ctl.ins) begin
      if (prev_gt) begin
        key     <= prev_key;
        payload <= prev_payload;
      end else if (gt || at_end) begin
        key     <= req_key;
        payload <= req_payload;
      end
    end else if (ctl.del) begin
      if (gt || eq) begin
        key     <= next_key;
        payload <= next_payload;
      end
    end
  end

endmodule

@@ rtl/sktb_grp.sv @@
// Registered match reduction over one group of cells: any-match flag and
// the payload of the matching cell. Depends on sktb_pkg.
module sktb_grp (
  input  logic               clk,
  input  logic [sktb_pkg::GRP-1:0] eq,
  input  sktb_pkg::payload_t pay [sktb_pkg::GRP],
  output logic               any,
  output sktb_pkg::payload_t orpay
);
  import sktb_pkg::*;

  payload_t orpay_next;

  always_comb begin
    orpay_next = '0;
    for (int i = 0; i < GRP; i++) begin
      orpay_next = orpay_next | (eq[i] ? pay[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    any   <= |eq;
    orpay <= orpay_next;
  end

endmodule

@@ tb/testbench.sv @@
// Testbench for sorted_key_table_unit: insert, delete and lookup requests with random
// idle gaps on both channels, each result checked against a behavioral copy of the table.
// Depends on sktb_pkg, sktb_req_if, sktb_rsp_if and the RTL of the unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sktb_pkg::*;

  localparam req_type_t REQ_LOOKUP = 2'd2;
  localparam req_type_t REQ_SPARE = 2'd3;
  localparam key_t KEY_MIN = 32'sh8000_0000;
  localparam key_t KEY_MAX = 32'sh7fff_ffff;
  localparam int MAX_IDLE = 10;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 250000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 194;
  localparam int POOL_SIZE = 72;

  typedef struct {
    req_type_t op;
    key_t      key;
    payload_t  payload;
    int        gap;
    bit        drain;
  } table_request_t;

  typedef struct packed {
    status_t    status;
    payload_t   found_payload;
    logic [6:0] entry_count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sktb_req_if req_ch ();
  sktb_rsp_if rsp_ch ();

  sorted_key_table_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  table_request_t pending_requests[$];
  table_result_t  expected_results[$];
  key_t           table_keys[CAPACITY];
  payload_t       table_payloads[CAPACITY];
  int             table_size;
  key_t           key_pool[POOL_SIZE];
  int             results_owed = 0;
  int             results_seen = 0;
  int             error_count = 0;
  int             cycle_count = 0;
  int             idle_left = 0;
  int             stall_left = 0;
  bit             armed = 1'b0;
  bit             sender_calm = 1'b0;
  bit             receiver_calm = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one request to the table copy and returns the result it must produce.
  function automatic table_result_t apply_request(req_type_t op, key_t k, payload_t p);
    table_result_t r;
    int hit;
    int pos;
    r.status = ST_OK;
    r.found_payload = '0;
    hit = -1;
    for (int i = 0; i < table_size; i++) begin
      if (table_keys[i] == k) hit = i;
    end
    if (op == OP_INS) begin
      if (table_size >= CAPACITY) begin
        r.status = ST_FULL;
      end else if (hit >= 0) begin
        r.status = ST_DUP;
      end else begin
        pos = table_size;
        for (int i = table_size - 1; i >= 0; i--) begin
          if (table_keys[i] > k) pos = i;
        end
        for (int j = table_size; j > pos; j--) begin
          table_keys[j] = table_keys[j - 1];
          table_payloads[j] = table_payloads[j - 1];
        end
        table_keys[pos] = k;
        table_payloads[pos] = p;
        table_size++;
      end
    end else if (table_size == 0) begin
      r.status = ST_EMPTY;
    end else if (hit < 0) begin
      r.status = ST_MISSING;
    end else begin
      r.found_payload = table_payloads[hit];
      if (op == OP_DEL) begin
        for (int j = hit; j + 1 < table_size; j++) begin
          table_keys[j] = table_keys[j + 1];
          table_payloads[j] = table_payloads[j + 1];
        end
        table_size--;
      end
    end
    r.entry_count = 7'(table_size);
    return r;
  endfunction

  task automatic add_request(req_type_t op, key_t k, payload_t p, bit drain = 1'b0);
    table_request_t item;
    item.op = op;
    item.key = k;
    item.payload = p;
    item.gap = sender_calm ? 0 : $urandom_range(0, MAX_IDLE);
    item.drain = drain;
    pending_requests.push_back(item);
  endtask

  // A request waits in place until accepted; a draining request is held back
  // until every earlier request has produced its result.
  always @(posedge clk) begin : drive_requests
    bit go;
    bit settle;
    if (rst) begin
      req_ch.valid <= 1'b0;
      armed = 1'b0;
    end else if (!(req_ch.valid && !req_ch.ready)) begin
      go = 1'b0;
      settle = 1'b0;
      if (req_ch.valid) begin
        void'(pending_requests.pop_front());
        armed = 1'b0;
        settle = 1'b1;
      end
      if (pending_requests.size() != 0) begin
        if (!armed) begin
          idle_left = pending_requests[0].gap;
          armed = 1'b1;
        end
        if (idle_left > 0) begin
          idle_left--;
        end else if (!pending_requests[0].drain || (!settle && results_owed == 0)) begin
          go = 1'b1;
        end
      end
      req_ch.valid <= go;
      if (go) begin
        req_ch.req_type <= pending_requests[0].op;
        req_ch.key <= pending_requests[0].key;
        req_ch.payload <= pending_requests[0].payload;
      end
    end
  end

  always @(posedge clk) begin : watch_table
    table_result_t want;
    int popped;
    int pushed;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      results_owed <= 0;
      table_size = 0;
      stall_left = 0;
    end else begin
      popped = 0;
      pushed = 0;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual status %0d payload %h count %0d",
                   $time, rsp_ch.status, rsp_ch.found_payload, rsp_ch.entry_count);
        end else begin
          popped = 1;
          want = expected_results.pop_front();
          if (rsp_ch.status !== want.status) begin
            error_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_ch.status);
          end
          if (rsp_ch.found_payload !== want.found_payload) begin
            error_count++;
            $display("%0t: found_payload expected %h actual %h", $time, want.found_payload,
                     rsp_ch.found_payload);
          end
          if (rsp_ch.entry_count !== want.entry_count) begin
            error_count++;
            $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                     rsp_ch.entry_count);
          end
        end
        results_seen++;
        if (results_seen % 150 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
        stall_left = receiver_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(apply_request(req_ch.req_type, req_ch.key, req_ch.payload));
        pushed = 1;
      end
      results_owed <= results_owed + pushed - popped;
      rsp_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : run_test
    int roll;
    bit fill_heavy;
    req_type_t op;
    key_t k;
    req_ch.valid = 1'b0;
    req_ch.req_type = OP_INS;
    req_ch.key = '0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;

    add_request(REQ_LOOKUP, 32'sd0, '1);
    add_request(OP_DEL, KEY_MIN, '0);
    add_request(OP_INS, KEY_MAX, '1);
    add_request(OP_INS, KEY_MIN, '0);
    add_request(OP_INS, 32'sd0, 64'h8000_0000_0000_0001);
    add_request(OP_INS, -32'sd1, 64'h0123_4567_89ab_cdef);
    add_request(OP_INS, 32'sd1, 64'h5555_5555_5555_5555);
    add_request(OP_INS, KEY_MAX, 64'haaaa_aaaa_aaaa_aaaa);
    add_request(REQ_LOOKUP, KEY_MIN, '0);
    add_request(REQ_LOOKUP, KEY_MAX, '0);
    add_request(REQ_SPARE, -32'sd1, '1);
    add_request(REQ_LOOKUP, 32'sd12345, '0);
    add_request(OP_DEL, 32'sd0, '0);
    add_request(OP_DEL, 32'sd0, '0);
    add_request(REQ_LOOKUP, 32'sd0, '0);
    add_request(OP_DEL, KEY_MIN, '0);
    add_request(OP_DEL, KEY_MAX, '0);
    add_request(OP_DEL, -32'sd1, '0);
    add_request(OP_DEL, 32'sd1, '0);
    add_request(REQ_SPARE, 32'sd1, '0);
    add_request(OP_DEL, KEY_MAX, '0);

    // Fill-heavy and drain-heavy phases alternate so the table swings between
    // full and empty; keys come mostly from a pool so hits and duplicates are common.
    for (int ph = 0; ph < PHASES; ph++) begin
      fill_heavy = (ph % 2 == 0);
      sender_calm = (ph == 3 || ph == 6);
      if (fill_heavy) begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          case ($urandom_range(0, 3))
            0: key_pool[i] = $urandom;
            1, 2: key_pool[i] = $urandom_range(0, 80) - 40;
            default: key_pool[i] = $urandom_range(0, 1) ? KEY_MAX - $urandom_range(0, 3)
                                                         : KEY_MIN + $urandom_range(0, 3);
          endcase
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) op = REQ_SPARE;
        else if (roll < (fill_heavy ? 70 : 18)) op = OP_INS;
        else if (roll < (fill_heavy ? 85 : 78)) op = OP_DEL;
        else op = REQ_LOOKUP;
        k = ($urandom_range(0, 9) == 0) ? key_t'($urandom)
                                         : key_pool[$urandom_range(0, POOL_SIZE - 1)];
        add_request(op, k, {$urandom, $urandom}, n == 0);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || results_owed != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
